// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each macro expands to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/pfi_pkg.sv =====
package pfi_pkg;

   localparam int unsigned DEFAULT_FRONT_DEPTH    = 64;
   localparam int unsigned DEFAULT_OBJECTIVE_BITS = 16;

   localparam int unsigned FUNC_BITS  = 2;
   localparam int unsigned TAG_BITS   = 17;
   localparam int unsigned INDEX_BITS = 6;
   localparam int unsigned COUNT_BITS = 7;

   localparam logic [FUNC_BITS-1:0] FUNC_INSERT = FUNC_BITS'(0);
   localparam logic [FUNC_BITS-1:0] FUNC_READ   = FUNC_BITS'(1);
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = FUNC_BITS'(2);
   localparam logic [FUNC_BITS-1:0] FUNC_NOP    = FUNC_BITS'(3);

endpackage

// ===== rtl/core/pareto_front_insert_top.sv =====
// Two-objective Pareto front (minimize load and bandwidth), kept sorted in one
// synchronous RAM by rising load and falling bandwidth.
// Input channel req_*: one item per operation (insert point, read entry, clear).
// Result channel rsp_*: exactly one item per input item, in order.
// Insert: the front is streamed through the RAM read port once; the write port
// lays down the new point and compacts or shifts the tail behind the read
// pointer, so a write never hits an entry that is still to be read.
// Timing: an insert streams front_size reads through the RAM, processes the last
// read data, closes the scan and then loads the rsp register; a reject or overflow
// can end the scan early. Read, clear and no-op go straight to loading the rsp
// register. The RAM scan loop sets the insert rate: the sequencer takes no new
// item until it is back in idle, after its result is loaded into the rsp register.
// req_ready is high only while the sequencer is idle. A finished result sits in
// the rsp register; the next item is accepted and processed while it waits,
// and the sequencer holds its own result until the rsp register frees up.
// Reset (synchronous, active high) empties the front and drops any pending
// result; the RAM needs no clearing since only entries below the size are read.
`include "assert_macros.svh"

module pareto_front_insert_top
   import pfi_pkg::*;
#(
   parameter int unsigned FRONT_DEPTH    = DEFAULT_FRONT_DEPTH,
   parameter int unsigned OBJECTIVE_BITS = DEFAULT_OBJECTIVE_BITS
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [FUNC_BITS-1:0]      req_func,
   input  logic [OBJECTIVE_BITS-1:0] req_point_load,
   input  logic [OBJECTIVE_BITS-1:0] req_point_bandwidth,
   input  logic [TAG_BITS-1:0]       req_point_tag,
   input  logic [INDEX_BITS-1:0]     req_read_index,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_accepted,
   output logic [COUNT_BITS-1:0]     rsp_removed_count,
   output logic                      rsp_overflow,
   output logic [COUNT_BITS-1:0]     rsp_front_size,
   output logic                      rsp_entry_valid,
   output logic [OBJECTIVE_BITS-1:0] rsp_entry_load,
   output logic [OBJECTIVE_BITS-1:0] rsp_entry_bandwidth,
   output logic [TAG_BITS-1:0]       rsp_entry_tag
);

   localparam int unsigned ADDR_W = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(FRONT_DEPTH + 1);
   localparam int unsigned CMP_W  = (CNT_W > INDEX_BITS) ? CNT_W : INDEX_BITS;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]       tag;
      logic [OBJECTIVE_BITS-1:0] bw;
      logic [OBJECTIVE_BITS-1:0] load;
   } entry_type;

   // Front storage: one entry per word, read-first, one read and one write port.
   entry_type front_mem_ff [FRONT_DEPTH];
   entry_type mem_rdata_ff;

   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   entry_type         mem_wdata;

   // Control state.
   state_type  state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic       dv_ff, dv_in;            // read data of the previous cycle is live
   logic       rsp_valid_ff, rsp_valid_in;

   // Operation working registers.
   logic [OBJECTIVE_BITS-1:0] pl_ff, pl_in;
   logic [OBJECTIVE_BITS-1:0] pb_ff, pb_in;
   logic [TAG_BITS-1:0]       pt_ff, pt_in;
   logic [CNT_W-1:0]          r_ff, r_in;        // next entry to read
   logic [CNT_W-1:0]          w_ff, w_in;        // next entry to write
   logic                      found_ff, found_in;  // sorted place reached
   logic                      in_run_ff, in_run_in; // still inside the dominated run
   logic                      prev_valid_ff, prev_valid_in;
   logic [OBJECTIVE_BITS-1:0] prev_bw_ff, prev_bw_in;
   entry_type                 carry_ff, carry_in;  // entry waiting for its write slot
   logic [CNT_W-1:0]          removed_ff, removed_in;

   // Finished result, waiting for the rsp register.
   logic             res_accepted_ff, res_accepted_in;
   logic [CNT_W-1:0] res_removed_ff, res_removed_in;
   logic             res_overflow_ff, res_overflow_in;
   logic             res_valid_ff, res_valid_in;

   // Output register.
   logic                      rsp_accepted_ff, rsp_accepted_in;
   logic [COUNT_BITS-1:0]     rsp_removed_ff, rsp_removed_in;
   logic                      rsp_overflow_ff, rsp_overflow_in;
   logic [COUNT_BITS-1:0]     rsp_size_ff, rsp_size_in;
   logic                      rsp_evalid_ff, rsp_evalid_in;
   entry_type                 rsp_entry_ff, rsp_entry_in;

   entry_type        point;
   logic [CNT_W-1:0] k;       // index of the entry in mem_rdata_ff during a scan
   logic             full;
   logic             load_rsp;
   logic             prev_blocks;

   assign point.load  = pl_ff;
   assign point.bw    = pb_ff;
   assign point.tag   = pt_ff;
   assign k           = r_ff - 1'b1;
   assign full        = (count_ff == CNT_W'(FRONT_DEPTH));
   assign prev_blocks = prev_valid_ff && (prev_bw_ff <= pb_ff);
   assign load_rsp    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      dv_in           = 1'b0;
      pl_in           = pl_ff;
      pb_in           = pb_ff;
      pt_in           = pt_ff;
      r_in            = r_ff;
      w_in            = w_ff;
      found_in        = found_ff;
      in_run_in       = in_run_ff;
      prev_valid_in   = prev_valid_ff;
      prev_bw_in      = prev_bw_ff;
      carry_in        = carry_ff;
      removed_in      = removed_ff;
      res_accepted_in = res_accepted_ff;
      res_removed_in  = res_removed_ff;
      res_overflow_in = res_overflow_ff;
      res_valid_in    = res_valid_ff;
      req_ready       = 1'b0;
      mem_re          = 1'b0;
      mem_raddr       = r_ff[ADDR_W-1:0];
      mem_we          = 1'b0;
      mem_waddr       = w_ff[ADDR_W-1:0];
      mem_wdata       = carry_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               pl_in           = req_point_load;
               pb_in           = req_point_bandwidth;
               pt_in           = req_point_tag;
               res_accepted_in = 1'b0;
               res_removed_in  = '0;
               res_overflow_in = 1'b0;
               res_valid_in    = 1'b0;
               state_in        = ST_DONE;
               unique case (req_func)
                  FUNC_INSERT: begin
                     r_in          = '0;
                     found_in      = 1'b0;
                     in_run_in     = 1'b0;
                     prev_valid_in = 1'b0;
                     removed_in    = '0;
                     state_in      = ST_SCAN;
                  end
                  FUNC_READ: begin
                     mem_re       = 1'b1;
                     mem_raddr    = ADDR_W'(req_read_index);
                     res_valid_in = CMP_W'(req_read_index) < CMP_W'(count_ff);
                  end
                  FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // Stream reads; process each entry in the cycle after its read.
            mem_re = (r_ff < count_ff);
            dv_in  = mem_re;
            if (mem_re) begin
               r_in = r_ff + 1'b1;
            end
            if (dv_ff) begin
               if (!found_ff) begin
                  if (mem_rdata_ff.load < pl_ff) begin
                     prev_valid_in = 1'b1;
                     prev_bw_in    = mem_rdata_ff.bw;
                  end else if (prev_blocks || ((mem_rdata_ff.load == pl_ff) &&
                                               (mem_rdata_ff.bw <= pb_ff))) begin
                     // Dominated or tied: drop the point, front unchanged.
                     state_in = ST_DONE;
                  end else if (mem_rdata_ff.bw >= pb_ff) begin
                     // First dominated entry: new point takes its slot.
                     found_in   = 1'b1;
                     in_run_in  = 1'b1;
                     removed_in = CNT_W'(1);
                     carry_in   = point;
                     w_in       = k;
                  end else if (full) begin
                     res_overflow_in = 1'b1;
                     state_in        = ST_DONE;
                  end else begin
                     // Nothing removed: write the point, shift the tail up by one.
                     found_in  = 1'b1;
                     in_run_in = 1'b0;
                     mem_we    = 1'b1;
                     mem_waddr = k[ADDR_W-1:0];
                     mem_wdata = point;
                     w_in      = k + 1'b1;
                     carry_in  = mem_rdata_ff;
                  end
               end else if (in_run_ff && (mem_rdata_ff.bw >= pb_ff)) begin
                  removed_in = removed_ff + 1'b1;
               end else begin
                  in_run_in = 1'b0;
                  mem_we    = 1'b1;
                  w_in      = w_ff + 1'b1;
                  carry_in  = mem_rdata_ff;
               end
            end else if (!mem_re) begin
               // Scan complete.
               state_in = ST_DONE;
               if (found_ff) begin
                  mem_we          = 1'b1;
                  count_in        = w_ff + 1'b1;
                  res_accepted_in = 1'b1;
                  res_removed_in  = removed_ff;
               end else if (prev_blocks) begin
                  res_accepted_in = 1'b0;
               end else if (full) begin
                  res_overflow_in = 1'b1;
               end else begin
                  // Point goes after every entry.
                  mem_we          = 1'b1;
                  mem_waddr       = count_ff[ADDR_W-1:0];
                  mem_wdata       = point;
                  count_in        = count_ff + 1'b1;
                  res_accepted_in = 1'b1;
               end
            end
         end

         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load from the sequencer, hold while stalled.
   always_comb begin
      rsp_valid_in    = (rsp_valid_ff && !rsp_ready) || load_rsp;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_removed_in  = rsp_removed_ff;
      rsp_overflow_in = rsp_overflow_ff;
      rsp_size_in     = rsp_size_ff;
      rsp_evalid_in   = rsp_evalid_ff;
      rsp_entry_in    = rsp_entry_ff;
      if (load_rsp) begin
         rsp_accepted_in = res_accepted_ff;
         rsp_removed_in  = COUNT_BITS'(res_removed_ff);
         rsp_overflow_in = res_overflow_ff;
         rsp_size_in     = COUNT_BITS'(count_ff);
         rsp_evalid_in   = res_valid_ff;
         rsp_entry_in    = res_valid_ff ? mem_rdata_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         front_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= front_mem_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pl_ff           <= pl_in;
      pb_ff           <= pb_in;
      pt_ff           <= pt_in;
      r_ff            <= r_in;
      w_ff            <= w_in;
      found_ff        <= found_in;
      in_run_ff       <= in_run_in;
      prev_valid_ff   <= prev_valid_in;
      prev_bw_ff      <= prev_bw_in;
      carry_ff        <= carry_in;
      removed_ff      <= removed_in;
      res_accepted_ff <= res_accepted_in;
      res_removed_ff  <= res_removed_in;
      res_overflow_ff <= res_overflow_in;
      res_valid_ff    <= res_valid_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_removed_ff  <= rsp_removed_in;
      rsp_overflow_ff <= rsp_overflow_in;
      rsp_size_ff     <= rsp_size_in;
      rsp_evalid_ff   <= rsp_evalid_in;
      rsp_entry_ff    <= rsp_entry_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_accepted_ff;
   assign rsp_removed_count   = rsp_removed_ff;
   assign rsp_overflow        = rsp_overflow_ff;
   assign rsp_front_size      = rsp_size_ff;
   assign rsp_entry_valid     = rsp_evalid_ff;
   assign rsp_entry_load      = rsp_entry_ff.load;
   assign rsp_entry_bandwidth = rsp_entry_ff.bw;
   assign rsp_entry_tag       = rsp_entry_ff.tag;

   `ASSERT_IMPL(a_size_bound, clock, reset, 1'b1, count_ff <= CNT_W'(FRONT_DEPTH),
                "front size beyond depth")
   `ASSERT_IMPL(a_write_behind_read, clock, reset, mem_we && mem_re,
                mem_waddr < mem_raddr, "write overtook read pointer")
   `ASSERT_IMPL(a_overflow_excl, clock, reset, rsp_valid_ff && rsp_overflow_ff,
                !rsp_accepted_ff && (rsp_removed_ff == '0), "overflow with accept or removal")
   `ASSERT_NEXT(a_clear_empties, clock, reset,
                req_valid && req_ready && (req_func == FUNC_CLEAR), count_ff == '0,
                "clear left entries")

endmodule
